@@ rtl/sps_pkg.sv @@
// Shared types and constants of the sector request page segmenter.
`default_nettype none
package sps_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned PAGE_W = 46;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned PCNT_W = 7;
  localparam int unsigned BMP_W  = 64;
  localparam int unsigned LG_W   = 3;
  localparam int unsigned OFS_W  = 6;

  localparam logic [LG_W-1:0] LG_MIN = 3'd2;
  localparam logic [LG_W-1:0] LG_MAX = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] REG_STREAM_START = 2'd0;
  localparam logic [1:0] REG_STREAM_END   = 2'd1;
  localparam logic [1:0] REG_PAGE_LOG2    = 2'd2;

  // Result error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ZERO_SIZE = 2'd1;
  localparam logic [1:0] ERR_START_OOR = 2'd2;
  localparam logic [1:0] ERR_SPAN_END  = 2'd3;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_CHK_LO   = 5'b00010,
    ST_CHK_HI   = 5'b00100,
    ST_CHK_SPAN = 5'b01000,
    ST_SEG      = 5'b10000
  } state_e;

  // One page transaction as worked out by the slicer.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [PCNT_W-1:0] cnt;
    logic [BMP_W-1:0]  bmp;
    logic              last;
  } slice_t;

endpackage
`default_nettype wire

@@ rtl/sps_alu.sv @@
// Shared 48-bit add/subtract unit with borrow output.
`default_nettype none
module sps_alu
  import sps_pkg::*;
(
  input  alu_op_e           op_i,
  input  logic [ADDR_W-1:0] a_i,
  input  logic [ADDR_W-1:0] b_i,
  output logic [ADDR_W-1:0] res_o,
  output logic              borrow_o
);

  logic [ADDR_W-1:0] b_eff;
  logic [ADDR_W:0]   sum;

  assign b_eff = (op_i == ALU_SUB) ? ~b_i : b_i;
  assign sum   = {1'b0, a_i} + {1'b0, b_eff} + {{ADDR_W{1'b0}}, (op_i == ALU_SUB)};

  assign res_o = sum[ADDR_W-1:0];
  // A subtraction borrows when no carry leaves the top bit.
  assign borrow_o = (op_i == ALU_SUB) && !sum[ADDR_W];

endmodule
`default_nettype wire

@@ rtl/sps_slice.sv @@
// Page slicer: size, bitmap and page number of the next transaction.
`default_nettype none
module sps_slice
  import sps_pkg::*;
(
  input  logic [OFS_W-1:0]  lsa_ofs_i,
  input  logic [ADDR_W-1:0] rel_i,
  input  logic [CNT_W-1:0]  rem_i,
  input  logic [LG_W-1:0]   lg_i,
  output slice_t            slice_o
);

  logic [PCNT_W-1:0] psz;
  logic [OFS_W-1:0]  pmask;
  logic [PCNT_W-1:0] tsz_page;
  logic [PCNT_W-1:0] tsz;
  logic              last;
  logic [BMP_W-1:0]  mask;
  logic [ADDR_W-1:0] rel_page;

  always_comb begin
    psz      = PCNT_W'(1) << lg_i;
    pmask    = OFS_W'(psz - PCNT_W'(1));
    tsz_page = psz - {1'b0, lsa_ofs_i & pmask};
    last     = {1'b0, tsz_page} >= rem_i;
    tsz      = last ? rem_i[PCNT_W-1:0] : tsz_page;
    mask     = tsz[PCNT_W-1] ? {BMP_W{1'b1}} : ~({BMP_W{1'b1}} << tsz);
    rel_page = rel_i >> lg_i;
  end

  assign slice_o.page = rel_page[PAGE_W-1:0];
  assign slice_o.cnt  = tsz;
  assign slice_o.bmp  = mask << (rel_i[OFS_W-1:0] & pmask);
  assign slice_o.last = last;

endmodule
`default_nettype wire

@@ rtl/sector_request_page_segmenter.sv @@
// Top level of the sector request page segmenter: sequencer, registers and output stage.
// A good request's first word is registered in page stepping, after the low, high and
// span checks; an error word in the failing check (zero size or start below the stream
// in the low one, start above it in the high one, span in the span one). Pages go out one
// per cycle while the output has room; range checks share the adder; requests never overlap.
// Reset (rst_ni low, async) clears sequencer and output valid; stream 0..all ones, log2 3.
`default_nettype none
module sector_request_page_segmenter
  import sps_pkg::*;
#(
  parameter int unsigned MAX_REQUEST_SECTORS = 128,
  parameter int unsigned ADDRESS_BITS        = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [ADDR_W-1:0]   cfg_data_i,

  // Request channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ADDR_W-1:0]   start_sector_i,
  input  logic [CNT_W-1:0]    sector_count_i,
  input  logic                is_read_i,

  // Transaction channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PAGE_W-1:0]   logical_page_o,
  output logic [PCNT_W-1:0]   page_sector_count_o,
  output logic [BMP_W-1:0]    sector_bitmap_o,
  output logic                read_flag_o,
  output logic [1:0]          error_code_o,
  output logic                last_of_run_o
);

  // Addresses are confined to ADDRESS_BITS; with 48 or more the mask keeps every bit.
  localparam logic [ADDR_W-1:0] AddrMask = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                           ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [CNT_W-1:0]  MaxCnt   = CNT_W'(MAX_REQUEST_SECTORS);

  // Configuration registers.
  logic [ADDR_W-1:0] lo_q, hi_q;
  logic [LG_W-1:0]   lg_q;
  logic [ADDR_W-1:0] lo_m, hi_m;
  logic [LG_W-1:0]   lg_sat;

  // Request working registers.
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] lsa_q;
  logic [CNT_W-1:0]  count_q;
  logic              rd_q;
  logic [ADDR_W-1:0] rel_q, rel_d;
  logic [ADDR_W-1:0] span_q, span_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [OFS_W-1:0]  ofs_q, ofs_d;

  // Output word register.
  logic              out_valid_q;
  logic [PAGE_W-1:0] page_q;
  logic [PCNT_W-1:0] pcnt_q;
  logic [BMP_W-1:0]  bmp_q;
  logic              rdf_q;
  logic [1:0]        err_q;
  logic              last_q;

  // Shared adder controls and the slicer result.
  alu_op_e           alu_op;
  logic [ADDR_W-1:0] alu_a, alu_b, alu_res;
  logic              alu_borrow;
  slice_t            slice;

  logic              accept;
  logic              can_emit;
  logic              emit;
  logic [1:0]        emit_err;
  logic              span_bad;

  assign lo_m   = lo_q & AddrMask;
  assign hi_m   = hi_q & AddrMask;
  assign lg_sat = (lg_q < LG_MIN) ? LG_MIN : ((lg_q > LG_MAX) ? LG_MAX : lg_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The output register takes a new word when empty or being drained this cycle.
  assign can_emit   = !out_valid_q || out_ready_i;

  // The span fails on oversize or when count - 1 exceeds hi - start.
  assign span_bad = (count_q > MaxCnt) ||
                    ((span_q[ADDR_W-1:CNT_W] == '0) &&
                     ((count_q - CNT_W'(1)) > span_q[CNT_W-1:0]));

  sps_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .borrow_o(alu_borrow)
  );

  sps_slice u_slice (
    .lsa_ofs_i(ofs_q),
    .rel_i    (rel_q),
    .rem_i    (rem_q),
    .lg_i     (lg_sat),
    .slice_o  (slice)
  );

  // The adder serves start - low in the first check, high - start in the second,
  // and the running relative address during page stepping.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = lsa_q;
    alu_b  = lo_m;
    case (state_q)
      ST_CHK_HI: begin
        alu_a = hi_m;
        alu_b = lsa_q;
      end
      ST_SEG: begin
        alu_op = ALU_ADD;
        alu_a  = rel_q;
        alu_b  = {{(ADDR_W-PCNT_W){1'b0}}, slice.cnt};
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    rel_d    = rel_q;
    span_d   = span_q;
    rem_d    = rem_q;
    ofs_d    = ofs_q;
    emit     = 1'b0;
    emit_err = ERR_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CHK_LO;
        end
      end
      ST_CHK_LO: begin
        // Zero size is tested before the range.
        if (count_q == '0) begin
          emit_err = ERR_ZERO_SIZE;
          emit     = can_emit;
          if (can_emit) state_d = ST_IDLE;
        end else if (alu_borrow) begin
          emit_err = ERR_START_OOR;
          emit     = can_emit;
          if (can_emit) state_d = ST_IDLE;
        end else begin
          rel_d   = alu_res;
          state_d = ST_CHK_HI;
        end
      end
      ST_CHK_HI: begin
        if (alu_borrow) begin
          emit_err = ERR_START_OOR;
          emit     = can_emit;
          if (can_emit) state_d = ST_IDLE;
        end else begin
          span_d  = alu_res;
          state_d = ST_CHK_SPAN;
        end
      end
      ST_CHK_SPAN: begin
        if (span_bad) begin
          emit_err = ERR_SPAN_END;
          emit     = can_emit;
          if (can_emit) state_d = ST_IDLE;
        end else begin
          rem_d   = count_q;
          ofs_d   = lsa_q[OFS_W-1:0];
          state_d = ST_SEG;
        end
      end
      ST_SEG: begin
        // One page transaction per cycle while the output stage has room.
        if (can_emit) begin
          emit  = 1'b1;
          rel_d = alu_res;
          rem_d = rem_q - {1'b0, slice.cnt};
          ofs_d = ofs_q + slice.cnt[OFS_W-1:0];
          if (slice.last) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= {ADDR_W{1'b1}};
      lg_q        <= 3'd3;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STREAM_START: lo_q <= cfg_data_i;
          REG_STREAM_END:   hi_q <= cfg_data_i;
          REG_PAGE_LOG2:    lg_q <= cfg_data_i[LG_W-1:0];
          default:          lg_q <= lg_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lsa_q   <= start_sector_i & AddrMask;
      count_q <= sector_count_i;
      rd_q    <= is_read_i;
    end
    rel_q  <= rel_d;
    span_q <= span_d;
    rem_q  <= rem_d;
    ofs_q  <= ofs_d;
    if (emit) begin
      rdf_q <= rd_q;
      err_q <= emit_err;
      if (emit_err == ERR_NONE) begin
        page_q <= slice.page;
        pcnt_q <= slice.cnt;
        bmp_q  <= slice.bmp;
        last_q <= slice.last;
      end else begin
        page_q <= '0;
        pcnt_q <= '0;
        bmp_q  <= '0;
        last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign logical_page_o      = page_q;
  assign page_sector_count_o = pcnt_q;
  assign sector_bitmap_o     = bmp_q;
  assign read_flag_o         = rdf_q;
  assign error_code_o        = err_q;
  assign last_of_run_o       = last_q;

`ifndef NO_ASSERTIONS
  // An error word always closes its request.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != ERR_NONE) |-> last_of_run_o)
    else $error("error word without last_of_run");

  // A good transaction covers at least one sector and marks it in the bitmap.
  a_ok_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o == ERR_NONE) |->
      (page_sector_count_o != '0 && sector_bitmap_o != '0))
    else $error("empty good transaction");

  // Page stepping never runs with nothing left of the request.
  a_seg_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEG) |-> (rem_q != '0))
    else $error("page step with no sectors remaining");

  // An accepted request starts with the low-bound check.
  a_accept_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CHK_LO))
    else $error("accepted request did not enter checking");
`endif

endmodule
`default_nettype wire
